// ----- src/cdq_pkg.sv -----
// Shared types and constants for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic               ok;
    logic               rd_ok;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } res_meta_t;

endpackage

// ----- src/cdq_ram.sv -----
// Single-port synchronous word store with a registered read port.
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [AW-1:0]              addr,
  input  logic [cdq_pkg::WORD_W-1:0] wdata,
  output logic [cdq_pkg::WORD_W-1:0] rdata
);

  logic [cdq_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- src/cdq_ctrl.sv -----
// Front index and count registers, command decode and store address generation.
`timescale 1ns / 1ps

module cdq_ctrl #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [2:0]         command,
  output logic               we,
  output logic               re,
  output logic [AW-1:0]      addr,
  output cdq_pkg::res_meta_t meta
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_C = AW'(DEPTH - 1);

  logic [AW-1:0] front, front_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail, back, front_dec, front_inc;
  logic          full, empty, ok, rd_ok, wr, rd;

  always_comb begin
    full = (cnt == FULL_C);
    empty = (cnt == '0);
    tail_sum = {1'b0, front} + SW'(cnt);
    tail = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
    back = (tail == '0) ? LAST_C : tail - AW'(1);
    front_dec = (front == '0) ? LAST_C : front - AW'(1);
    front_inc = (front == LAST_C) ? '0 : front + AW'(1);

    front_next = front;
    cnt_next = cnt;
    addr = front;
    wr = 1'b0;
    rd = 1'b0;
    ok = 1'b0;
    rd_ok = 1'b0;
    unique case (cdq_pkg::cmd_t'(command))
      cdq_pkg::CMD_PUSH_BACK: begin
        if (!full) begin
          wr = 1'b1;
          addr = tail;
          cnt_next = cnt + CW'(1);
          ok = 1'b1;
        end
      end
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (!full) begin
          wr = 1'b1;
          addr = front_dec;
          front_next = front_dec;
          cnt_next = cnt + CW'(1);
          ok = 1'b1;
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (!empty) begin
          rd = 1'b1;
          front_next = front_inc;
          cnt_next = cnt - CW'(1);
          ok = 1'b1;
          rd_ok = 1'b1;
        end
      end
      cdq_pkg::CMD_POP_BACK: begin
        if (!empty) begin
          rd = 1'b1;
          addr = back;
          cnt_next = cnt - CW'(1);
          ok = 1'b1;
          rd_ok = 1'b1;
        end
      end
      cdq_pkg::CMD_PEEK_FRONT: begin
        if (!empty) begin
          rd = 1'b1;
          ok = 1'b1;
          rd_ok = 1'b1;
        end
      end
      cdq_pkg::CMD_PEEK_BACK: begin
        if (!empty) begin
          rd = 1'b1;
          addr = back;
          ok = 1'b1;
          rd_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase

    we = accept & wr;
    re = accept & rd;
    meta.ok = ok;
    meta.rd_ok = rd_ok;
    meta.count = cdq_pkg::COUNT_W'(cnt_next);
    meta.is_empty = (cnt_next == '0);
    meta.is_full = (cnt_next == FULL_C);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      cnt <= '0;
    end else if (accept) begin
      front <= front_next;
      cnt <= cnt_next;
    end
  end

endmodule

// ----- src/circular_deque.sv -----
// Circular deque: a ring store of signed words with push, pop and peek at either end.
//
// The command channel (cmd_valid, cmd_stall, command, data_in) takes one item,
// a push, pop or peek at the front or back. Every command item gives exactly one
// result item on the result channel (res_valid, res_stall, ok, data_out, count,
// is_empty, is_full). The result appears in the cycle after the command is taken,
// because the word store is a synchronous memory with a registered read port.
// The front index and the count live in registers and are updated as the command
// is taken, so one item per cycle is sustained while the result receiver does
// not stall; the single store port is the limit. A push onto a full deque, or a
// pop or peek on an empty one, reports ok low and changes nothing; data_out is
// zero unless a pop or peek succeeded. While the result receiver stalls, the
// pending result holds and cmd_stall is raised, so no further command is taken.
// A synchronous reset empties the deque and drops any pending result; the store
// contents are left as they are and are never read before being written again.
`timescale 1ns / 1ps

module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  logic [2:0]                        command,
  input  logic signed [cdq_pkg::WORD_W-1:0] data_in,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic                              ok,
  output logic signed [cdq_pkg::WORD_W-1:0] data_out,
  output logic [cdq_pkg::COUNT_W-1:0]       count,
  output logic                              is_empty,
  output logic                              is_full
);

  localparam int AW = $clog2(DEPTH);

  logic                       accept;
  logic                       we, re;
  logic [AW-1:0]              addr;
  logic [cdq_pkg::WORD_W-1:0] rdata;
  cdq_pkg::res_meta_t         meta, meta_q;

  assign cmd_stall = res_valid & res_stall;
  assign accept = cmd_valid & ~cmd_stall;

  cdq_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .command(command),
    .we     (we),
    .re     (re),
    .addr   (addr),
    .meta   (meta)
  );

  cdq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk  (clk),
    .we   (we),
    .re   (re),
    .addr (addr),
    .wdata(data_in),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= accept | cmd_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta_q <= meta;
    end
  end

  assign ok = meta_q.ok;
  assign data_out = meta_q.rd_ok ? rdata : '0;
  assign count = meta_q.count;
  assign is_empty = meta_q.is_empty;
  assign is_full = meta_q.is_full;

endmodule

// ----- src/cdq_checker.sv -----
// Port-level checks for the circular deque and their binding to the top level.
`timescale 1ns / 1ps

module cdq_checker #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              cmd_valid,
  input logic                              cmd_stall,
  input logic [2:0]                        command,
  input logic signed [cdq_pkg::WORD_W-1:0] data_in,
  input logic                              res_valid,
  input logic                              res_stall,
  input logic                              ok,
  input logic signed [cdq_pkg::WORD_W-1:0] data_out,
  input logic [cdq_pkg::COUNT_W-1:0]       count,
  input logic                              is_empty,
  input logic                              is_full
);

  logic unused_ports;
  assign unused_ports = ^{command, data_in, DEPTH};

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> res_valid)
    else $error("Accepted command item gave no result item.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !ok |-> data_out == '0)
    else $error("Failed command item returned a nonzero word.");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_empty |-> count == '0 && !is_full)
    else $error("Empty flag disagrees with count or full flag.");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> cmd_stall)
    else $error("Command item taken while a result item is held.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(data_out) && $stable(count))
    else $error("Stalled result item changed.");

endmodule

bind circular_deque cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);
